/* rtl/scd_pkg.sv */
package scd_pkg;

  localparam int unsigned AccW   = 21;
  localparam int unsigned MagW   = 20;
  localparam int unsigned OpW    = 9;
  localparam int unsigned ProdW  = MagW + OpW;
  localparam int unsigned Digits = 6;
  localparam int unsigned BcdW   = 4 * Digits;
  localparam int unsigned CntW   = 5;

  localparam logic [3:0] FUNC_ADD = 4'd1;
  localparam logic [3:0] FUNC_SUB = 4'd2;
  localparam logic [3:0] FUNC_MUL = 4'd4;
  localparam logic [3:0] FUNC_DIV = 4'd8;

  localparam logic [CntW-1:0] MUL_STEPS = 5'd9;
  localparam logic [CntW-1:0] DIV_STEPS = 5'd20;
  localparam logic [CntW-1:0] BCD_STEPS = 5'd20;

  localparam logic [ProdW-1:0]       MAG_MAX = 29'd999999;
  localparam logic signed [AccW:0]   SUM_MAX = 22'sd999999;
  localparam logic signed [AccW:0]   SUM_MIN = -22'sd999999;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARITH,
    ST_BCD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic                   done;
    logic                   div_zero;
    logic signed [AccW-1:0] value;
  } arith_res_t;

  typedef struct packed {
    logic            done;
    logic [BcdW-1:0] digits;
  } bcd_res_t;

  function automatic logic [7:0] seg7(input logic [3:0] d);
    logic [7:0] code;
    unique case (d)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* rtl/scd_arith.sv */
module scd_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [3:0]             func_i,
  input  logic [9:0]             switch_word_i,
  input  logic signed [20:0]     acc_i,
  output scd_pkg::arith_res_t    res_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        mul_q, mul_d;
  logic        neg_q, neg_d;
  logic        dz_q, dz_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [28:0] prod_q, prod_d;
  logic [28:0] mcand_q, mcand_d;
  logic [8:0]  opnd_q, opnd_d;
  logic [19:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic signed [20:0] value_q, value_d;

  logic [8:0]         op_mag;
  logic               op_neg;
  logic signed [21:0] op_s;
  logic signed [21:0] sum;
  logic [20:0]        acc_abs;
  logic [9:0]         rem_sh;
  logic               rem_ge;
  logic [28:0]        fin_mag;
  logic [20:0]        fin_clamp;

  always_comb begin
    op_mag    = switch_word_i[8:0];
    op_neg    = switch_word_i[9];
    op_s      = op_neg ? -$signed({13'd0, op_mag}) : $signed({13'd0, op_mag});
    sum       = (func_i == scd_pkg::FUNC_SUB) ? 22'(acc_i) - op_s : 22'(acc_i) + op_s;
    acc_abs   = acc_i[20] ? 21'(-acc_i) : acc_i;
    rem_sh    = {rem_q, quo_q[19]};
    rem_ge    = rem_sh >= {1'b0, opnd_q};
    fin_mag   = mul_q ? prod_q : {9'd0, quo_q};
    fin_clamp = (fin_mag > scd_pkg::MAG_MAX) ? 21'(scd_pkg::MAG_MAX) : {1'b0, fin_mag[19:0]};
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    mul_d   = mul_q;
    neg_d   = neg_q;
    dz_d    = dz_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    mcand_d = mcand_q;
    opnd_d  = opnd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    value_d = value_q;
    if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 5'd1;
        if (mul_q) begin
          if (opnd_q[0]) begin
            prod_d = prod_q + mcand_q;
          end
          mcand_d = {mcand_q[27:0], 1'b0};
          opnd_d  = {1'b0, opnd_q[8:1]};
        end else begin
          rem_d = rem_ge ? 9'(rem_sh - {1'b0, opnd_q}) : rem_sh[8:0];
          quo_d = {quo_q[18:0], rem_ge};
        end
      end else begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        value_d = neg_q ? (~fin_clamp + 21'd1) : fin_clamp;
      end
    end else if (start_i) begin
      dz_d   = 1'b0;
      neg_d  = op_neg ^ acc_i[20];
      opnd_d = op_mag;
      unique case (func_i)
        scd_pkg::FUNC_ADD, scd_pkg::FUNC_SUB: begin
          done_d = 1'b1;
          if (sum > scd_pkg::SUM_MAX) begin
            value_d = 21'(scd_pkg::SUM_MAX);
          end else if (sum < scd_pkg::SUM_MIN) begin
            value_d = 21'(scd_pkg::SUM_MIN);
          end else begin
            value_d = sum[20:0];
          end
        end
        scd_pkg::FUNC_MUL: begin
          busy_d  = 1'b1;
          mul_d   = 1'b1;
          cnt_d   = scd_pkg::MUL_STEPS;
          prod_d  = '0;
          mcand_d = {9'd0, acc_abs[19:0]};
        end
        scd_pkg::FUNC_DIV: begin
          if (op_mag == '0) begin
            done_d  = 1'b1;
            dz_d    = 1'b1;
            value_d = acc_i;
          end else begin
            busy_d = 1'b1;
            mul_d  = 1'b0;
            cnt_d  = scd_pkg::DIV_STEPS;
            quo_d  = acc_abs[19:0];
            rem_d  = '0;
          end
        end
        default: begin
          done_d  = 1'b1;
          value_d = acc_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mul_q  <= mul_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    dz_q    <= dz_d;
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
    opnd_q  <= opnd_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    value_q <= value_d;
  end

  assign res_o.done     = done_q;
  assign res_o.div_zero = dz_q;
  assign res_o.value    = value_q;

endmodule

/* rtl/scd_bcd.sv */
module scd_bcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [19:0]       bin_i,
  output scd_pkg::bcd_res_t res_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [19:0] bin_q, bin_d;
  logic [scd_pkg::BcdW-1:0] bcd_q, bcd_d;
  logic [scd_pkg::BcdW-1:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < scd_pkg::Digits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (busy_q) begin
      bcd_d = {bcd_adj[scd_pkg::BcdW-2:0], bin_q[19]};
      bin_d = {bin_q[18:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = scd_pkg::BCD_STEPS;
      bin_d  = bin_i;
      bcd_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done   = done_q;
  assign res_o.digits = bcd_q;

endmodule

/* rtl/saturating_calculator_display_core.sv */
// Saturating four-function calculator with a six-digit 7-segment readout.
// The input channel carries one button transaction: the button code on
// s_axis_tuser_i and the raw switch word in s_axis_tdata_i. Every accepted
// transaction yields exactly one output transaction holding the new
// accumulator, the segment codes of its absolute value, the sign LED and,
// on m_axis_tuser_o, the divide-by-zero flag.
// The block works on one transaction at a time. Add, subtract and the other
// codes are computed when the transaction is accepted, a multiply runs the
// serial shift-and-add unit and a divide the restoring divider; the
// binary-to-BCD converter then shifts one bit per cycle. The next
// transaction is taken in the cycle after the result is loaded.
// The result sits in an output register, so a stalled receiver does not stop
// the next transaction from being accepted and computed; only the final load
// waits for the register to empty. Reset clears the accumulator to zero and
// drops tvalid.
module saturating_calculator_display_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // switch_word[9:0], zero padding
  input  logic [3:0]  s_axis_tuser_i,   // func[3:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // total[20:0], seg_low_digits[51:21],
                                        // seg_high_digits[66:52], sign_led[67], zero padding
  output logic [0:0]  m_axis_tuser_o    // div_zero[0]
);

  scd_pkg::state_e     state_q, state_d;
  scd_pkg::arith_res_t arith_res;
  scd_pkg::bcd_res_t   bcd_res;

  logic signed [20:0] acc_q;
  logic               dz_q;
  logic               m_valid_q, m_valid_d;
  logic [71:0]        out_data_q;
  logic               out_dz_q;

  logic        s_accept;
  logic        bcd_start;
  logic        load_out;
  logic        out_free;
  logic [20:0] res_abs;
  logic [30:0] seg_low;
  logic [14:0] seg_high;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign res_abs  = arith_res.value[20] ? 21'(-arith_res.value) : arith_res.value;

  scd_arith u_arith (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (s_accept),
    .func_i        (s_axis_tuser_i),
    .switch_word_i (s_axis_tdata_i[9:0]),
    .acc_i         (acc_q),
    .res_o         (arith_res)
  );

  scd_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (res_abs[19:0]),
    .res_o   (bcd_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scd_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = scd_pkg::ST_ARITH;
        end
      end
      scd_pkg::ST_ARITH: begin
        if (arith_res.done) begin
          state_d = scd_pkg::ST_BCD;
        end
      end
      scd_pkg::ST_BCD: begin
        if (bcd_res.done) begin
          state_d = scd_pkg::ST_LOAD;
        end
      end
      scd_pkg::ST_LOAD: begin
        if (out_free) begin
          state_d = scd_pkg::ST_IDLE;
        end
      end
      default: state_d = scd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == scd_pkg::ST_IDLE);
    bcd_start       = (state_q == scd_pkg::ST_ARITH) && arith_res.done;
    load_out        = (state_q == scd_pkg::ST_LOAD) && out_free;
  end

  always_comb begin
    seg_low  = 31'({scd_pkg::seg7(bcd_res.digits[15:12]), scd_pkg::seg7(bcd_res.digits[11:8]),
                    scd_pkg::seg7(bcd_res.digits[7:4]), scd_pkg::seg7(bcd_res.digits[3:0])});
    seg_high = 15'({scd_pkg::seg7(bcd_res.digits[23:20]), scd_pkg::seg7(bcd_res.digits[19:16])});
    if (load_out) begin
      m_valid_d = 1'b1;
    end else begin
      m_valid_d = m_valid_q && !m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scd_pkg::ST_IDLE;
      acc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (bcd_start) begin
        acc_q <= arith_res.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bcd_start) begin
      dz_q <= arith_res.div_zero;
    end
    if (load_out) begin
      out_data_q <= {4'd0, acc_q[20], seg_high, seg_low, acc_q};
      out_dz_q   <= dz_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_dz_q;

endmodule

/* rtl/scd_checker.sv */
module scd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output transaction changed while stalled");

  // Only one transaction is in flight, so ready drops right after acceptance.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a transaction is in flight");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[20:0]) <= 21'sd999999) &&
      ($signed(m_axis_tdata_o[20:0]) >= -21'sd999999))
    else $error("total outside the saturation range");

  a_sign_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[67] == m_axis_tdata_o[20])
    else $error("sign LED disagrees with total");

endmodule

bind saturating_calculator_display_core scd_checker u_scd_checker (.*);

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_PRESSES = 1525;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam longint      SAT_LIMIT     = 999999;

  localparam logic [3:0] FUNC_NONE = 4'd0;
  localparam logic [3:0] FUNC_ALL  = scd_pkg::FUNC_ADD | scd_pkg::FUNC_SUB |
                                     scd_pkg::FUNC_MUL | scd_pkg::FUNC_DIV;

  localparam int unsigned DIR_COUNT = 24;
  localparam logic [3:0] DIR_CODE [DIR_COUNT] = '{
    scd_pkg::FUNC_ADD, scd_pkg::FUNC_MUL, scd_pkg::FUNC_MUL, FUNC_NONE,
    scd_pkg::FUNC_DIV, scd_pkg::FUNC_DIV, scd_pkg::FUNC_DIV, scd_pkg::FUNC_SUB,
    scd_pkg::FUNC_MUL, scd_pkg::FUNC_DIV, scd_pkg::FUNC_MUL, scd_pkg::FUNC_SUB,
    scd_pkg::FUNC_DIV, scd_pkg::FUNC_ADD | scd_pkg::FUNC_SUB, FUNC_ALL,
    scd_pkg::FUNC_MUL | scd_pkg::FUNC_DIV, scd_pkg::FUNC_ADD | scd_pkg::FUNC_MUL,
    scd_pkg::FUNC_MUL,
    scd_pkg::FUNC_ADD, scd_pkg::FUNC_SUB, scd_pkg::FUNC_DIV,
    scd_pkg::FUNC_SUB, scd_pkg::FUNC_DIV, scd_pkg::FUNC_ADD
  };
  localparam logic [9:0] DIR_SW [DIR_COUNT] = '{
    10'h1FF, 10'h1FF, 10'h1FF, 10'h155, 10'h000, 10'h200, 10'h007, 10'h3FF,
    10'h209, 10'h202, 10'h203, 10'h1FF, 10'h3FF, 10'h2AA, 10'h3FF,
    10'h001, 10'h000, 10'h000, 10'h200, 10'h201, 10'h003,
    10'h005, 10'h002, 10'h0F0
  };

  typedef struct packed {
    logic signed [20:0] total;
    logic [30:0]        seg_low;
    logic [14:0]        seg_high;
    logic               sign_led;
    logic               div_zero;
  } readout_t;

  class readout_checker;
    readout_t    pending_readouts[$];
    longint      total_acc;
    int unsigned mismatches;
    logic [7:0]  seg_of_digit [10];

    function new();
      total_acc    = 0;
      mismatches   = 0;
      seg_of_digit = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
    endfunction

    task report_mismatch(string what, longint want_v, longint got_v);
      mismatches++;
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, want_v, got_v, $realtime);
    endtask

    function void note_press(logic [3:0] code, logic [9:0] sw);
      longint      operand;
      longint      nxt;
      longint      mag;
      logic [47:0] segs;
      readout_t    r;
      operand = longint'(sw[8:0]);
      if (sw[9]) operand = -operand;
      nxt = total_acc;
      r.div_zero = 1'b0;
      case (code)
        scd_pkg::FUNC_ADD: nxt = total_acc + operand;
        scd_pkg::FUNC_SUB: nxt = total_acc - operand;
        scd_pkg::FUNC_MUL: nxt = total_acc * operand;
        scd_pkg::FUNC_DIV: begin
          if (operand != 0) nxt = total_acc / operand;
          else r.div_zero = 1'b1;
        end
        default: ;
      endcase
      if (nxt > SAT_LIMIT) nxt = SAT_LIMIT;
      else if (nxt < -SAT_LIMIT) nxt = -SAT_LIMIT;
      total_acc  = nxt;
      r.total    = nxt[20:0];
      r.sign_led = (nxt < 0);
      mag  = (nxt < 0) ? -nxt : nxt;
      segs = '0;
      for (int i = 0; i < 6; i++) begin
        segs[8*i +: 8] = seg_of_digit[mag % 10];
        mag = mag / 10;
      end
      r.seg_low  = segs[30:0];
      r.seg_high = segs[46:32];
      pending_readouts.push_back(r);
    endfunction

    task check_readout(logic [71:0] data, logic [0:0] flag);
      readout_t want;
      readout_t got;
      got.total    = data[20:0];
      got.seg_low  = data[51:21];
      got.seg_high = data[66:52];
      got.sign_led = data[67];
      got.div_zero = flag[0];
      if (pending_readouts.size() == 0) begin
        report_mismatch("unexpected transaction, total", 0, got.total);
      end else begin
        want = pending_readouts.pop_front();
        if (got.total !== want.total) report_mismatch("total", want.total, got.total);
        if (got.seg_low !== want.seg_low)
          report_mismatch("seg_low_digits", want.seg_low, got.seg_low);
        if (got.seg_high !== want.seg_high)
          report_mismatch("seg_high_digits", want.seg_high, got.seg_high);
        if (got.sign_led !== want.sign_led)
          report_mismatch("sign_led", want.sign_led, got.sign_led);
        if (got.div_zero !== want.div_zero)
          report_mismatch("div_zero", want.div_zero, got.div_zero);
      end
    endtask
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic [3:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [71:0] m_data;
  logic [0:0]  m_user;

  logic        calm       = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;

  readout_checker sb = new();

  saturating_calculator_display_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_readout(m_data, m_user);
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_ready = 1'b0;
    end else if (!calm && $urandom_range(999) == 0) begin
      stall_left = $urandom_range(60, 20);
      m_ready    = 1'b0;
    end else begin
      m_ready = calm || ($urandom_range(99) >= 13);
    end
  end

  task send_press(input logic [3:0] code, input logic [9:0] sw);
    if (!calm && $urandom_range(99) < 13) begin
      s_valid = 1'b0;
      repeat ($urandom_range(40, 1)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {6'b0, sw};
    s_user  = code;
    do @(posedge clk_i); while (!s_ready);
    sb.note_press(code, sw);
    @(negedge clk_i);
  endtask

  initial begin
    logic [3:0]  code;
    logic [9:0]  sw;
    int unsigned pick;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_COUNT; i++) send_press(DIR_CODE[i], DIR_SW[i]);

    for (int i = 0; i < RANDOM_PRESSES; i++) begin
      if (i == 700) begin
        s_valid = 1'b0;
        while (sb.pending_readouts.size() != 0) @(negedge clk_i);
      end
      calm = (i >= 1000 && i < 1300);
      pick = $urandom_range(99);
      if (pick < 20) begin
        code = 4'($urandom_range(15));
      end else begin
        case ($urandom_range(3))
          0: code = scd_pkg::FUNC_ADD;
          1: code = scd_pkg::FUNC_SUB;
          2: code = scd_pkg::FUNC_MUL;
          default: code = scd_pkg::FUNC_DIV;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 10) sw = {1'($urandom_range(1)), 9'd0};
      else if (pick < 40) sw = {1'($urandom_range(1)), 9'($urandom_range(12, 1))};
      else sw = 10'($urandom_range(1023));
      send_press(code, sw);
    end
    s_valid = 1'b0;
    calm    = 1'b0;

    while (sb.pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_readouts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/scd_pkg.sv
rtl/scd_arith.sv
rtl/scd_bcd.sv
rtl/saturating_calculator_display_core.sv
rtl/scd_checker.sv
tb/sv/tb_top.sv
